// ===== hdl/ibar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibar_pkg
// shared types, sizes and the color palette of the bitmap/attribute renderer
// ----------------------------------------------------------------------------
package ibar_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 192;
  localparam int BITMAP_SIZE   = 6144;
  localparam int ATTR_SIZE     = 768;
  localparam int STORE_SIZE    = BITMAP_SIZE + ATTR_SIZE;
  localparam int BM_AW         = $clog2(BITMAP_SIZE);
  localparam int AT_AW         = $clog2(ATTR_SIZE);

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef struct packed {
    logic        func;
    logic [12:0] addr;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [23:0] rgb;
    logic        frame_end;
  } out_item_t;

  // store port requests for one cycle
  typedef struct packed {
    logic             bm_we;
    logic [BM_AW-1:0] bm_waddr;
    logic             bm_re;
    logic [BM_AW-1:0] bm_raddr;
    logic             at_we;
    logic [AT_AW-1:0] at_waddr;
    logic             at_re;
    logic [AT_AW-1:0] at_raddr;
    logic [7:0]       wdata;
  } mem_req_t;

  // pixel travelling alongside its store reads
  typedef struct packed {
    logic       valid;
    logic [7:0] x;
    logic [7:0] y;
    logic [2:0] bit_sel;
    logic       frame_end;
  } pix_tag_t;

  typedef struct packed {
    logic clearing;
  } scan_status_t;

  function automatic logic [23:0] palette(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0:    c = 24'h000000;
      3'd1:    c = 24'h0000FF;
      3'd2:    c = 24'hFF0000;
      3'd3:    c = 24'hFF00FF;
      3'd4:    c = 24'h00FF00;
      3'd5:    c = 24'h00FFFF;
      3'd6:    c = 24'hFFFF00;
      3'd7:    c = 24'hFFFFFF;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/ibar_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibar_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ibar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ibar_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibar_scan
// clearing pass, write decode, raster position and store read addresses
// ----------------------------------------------------------------------------
module ibar_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ibar_pkg::in_item_t    in_item,
  input  logic                  pipe_free,
  output ibar_pkg::mem_req_t    mem_req,
  output ibar_pkg::pix_tag_t    pix_tag,
  output ibar_pkg::scan_status_t status
);

  logic                   clearing_r, clearing_nxt;
  logic [ibar_pkg::BM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]             line_r, line_nxt;
  logic [7:0]             col_r, col_nxt;
  logic [7:0]             row;
  logic                   accept;
  logic                   is_pixel;
  logic                   last;

  assign in_ready = !clearing_r && pipe_free;
  assign accept   = in_valid && in_ready;
  assign is_pixel = accept && (in_item.func == ibar_pkg::FUNC_PIXEL);

  // bitmap line to interleaved screen row
  assign row  = {line_r[7:6], line_r[2:0], line_r[5:3]};
  assign last = (line_r == 8'(ibar_pkg::SCREEN_HEIGHT - 1)) &&
                (col_r == 8'(ibar_pkg::SCREEN_WIDTH - 1));

  always_comb begin
    mem_req          = '0;
    mem_req.bm_raddr = {line_r, col_r[7:3]};
    mem_req.at_raddr = {row[7:3], col_r[7:3]};
    mem_req.bm_re    = is_pixel;
    mem_req.at_re    = is_pixel;
    if (clearing_r) begin
      mem_req.bm_we    = 1'b1;
      mem_req.bm_waddr = clr_cnt_r;
      mem_req.at_we    = clr_cnt_r < ibar_pkg::BM_AW'(ibar_pkg::ATTR_SIZE);
      mem_req.at_waddr = clr_cnt_r[ibar_pkg::AT_AW-1:0];
      mem_req.wdata    = 8'd0;
    end else begin
      mem_req.wdata    = in_item.data;
      mem_req.bm_waddr = in_item.addr[ibar_pkg::BM_AW-1:0];
      mem_req.at_waddr = in_item.addr[ibar_pkg::AT_AW-1:0];
      if (accept && (in_item.func == ibar_pkg::FUNC_WRITE)) begin
        mem_req.bm_we = in_item.addr < 13'(ibar_pkg::BITMAP_SIZE);
        mem_req.at_we = (in_item.addr >= 13'(ibar_pkg::BITMAP_SIZE)) &&
                        (in_item.addr < 13'(ibar_pkg::STORE_SIZE));
      end
    end
  end

  always_comb begin
    pix_tag.valid     = is_pixel;
    pix_tag.x         = col_r;
    pix_tag.y         = row;
    pix_tag.bit_sel   = ~col_r[2:0];
    pix_tag.frame_end = last;
  end

  assign status.clearing = clearing_r;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == ibar_pkg::BM_AW'(ibar_pkg::BITMAP_SIZE - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    if (is_pixel) begin
      if (col_r == 8'(ibar_pkg::SCREEN_WIDTH - 1)) begin
        col_nxt  = 8'd0;
        line_nxt = (line_r == 8'(ibar_pkg::SCREEN_HEIGHT - 1)) ? 8'd0 : line_r + 8'd1;
      end else begin
        col_nxt = col_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      line_r     <= 8'd0;
      col_r      <= 8'd0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      line_r     <= line_nxt;
      col_r      <= col_nxt;
    end
  end

endmodule

// ===== hdl/ibar_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibar_color
// read-data stage, ink/paper select, palette lookup and output register
// ----------------------------------------------------------------------------
module ibar_color (
  input  logic                clk,
  input  logic                rst_n,
  input  ibar_pkg::pix_tag_t  pix_tag,
  input  logic [7:0]          bm_rdata,
  input  logic [7:0]          at_rdata,
  output logic                pipe_free,
  output logic                out_valid,
  input  logic                out_ready,
  output ibar_pkg::out_item_t out_item
);

  logic                s1_valid_r;
  ibar_pkg::pix_tag_t  tag_r;
  logic                out_valid_r;
  ibar_pkg::out_item_t out_item_r, out_item_nxt;
  logic                s1_adv;
  logic                ink;

  assign s1_adv    = !out_valid_r || out_ready;
  assign pipe_free = !s1_valid_r || s1_adv;

  assign ink = bm_rdata[tag_r.bit_sel];

  always_comb begin
    out_item_nxt.pixel_x   = tag_r.x;
    out_item_nxt.pixel_y   = tag_r.y;
    out_item_nxt.rgb       = ink ? ibar_pkg::palette(at_rdata[2:0])
                                 : ibar_pkg::palette(at_rdata[5:3]);
    out_item_nxt.frame_end = tag_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pipe_free) begin
        s1_valid_r <= pix_tag.valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_free) begin
      tag_r <= pix_tag;
    end
    if (s1_adv && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/interleaved_bitmap_attribute_render.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_bitmap_attribute_render
// bitmap/attribute video renderer with a write port into its video store
// ----------------------------------------------------------------------------
// The video store is split into a 6144-byte bitmap memory and a 768-byte
// attribute memory, each with its own read port, so a pixel item reads both
// in the same cycle; one item is taken every cycle that in_ready is high.
// A pixel result passes the store read, then the output register. Write
// items produce no result; a write is visible to any pixel item that
// follows it. After reset the store is cleared to zero by a pass over 6144
// addresses (one bitmap byte and, for the first 768, one attribute byte
// each cycle); in_ready stays low for that time. in_ready also drops while a
// result waits in the output register and another is already in flight.
// ----------------------------------------------------------------------------
module interleaved_bitmap_attribute_render (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ibar_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ibar_pkg::out_item_t out_item
);

  ibar_pkg::mem_req_t     mem_req;
  ibar_pkg::pix_tag_t     pix_tag;
  ibar_pkg::scan_status_t status;
  logic                   pipe_free;
  logic [7:0]             bm_rdata;
  logic [7:0]             at_rdata;

  // position counter, write decode and the clearing pass
  ibar_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .pipe_free (pipe_free),
    .mem_req   (mem_req),
    .pix_tag   (pix_tag),
    .status    (status)
  );

  // bitmap bytes, 32 per bitmap line
  ibar_ram #(
    .WIDTH (8),
    .DEPTH (ibar_pkg::BITMAP_SIZE)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (mem_req.bm_we),
    .waddr (mem_req.bm_waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.bm_re),
    .raddr (mem_req.bm_raddr),
    .rdata (bm_rdata)
  );

  // attribute bytes, 32 per 8x8 cell row
  ibar_ram #(
    .WIDTH (8),
    .DEPTH (ibar_pkg::ATTR_SIZE)
  ) u_attr_ram (
    .clk   (clk),
    .we    (mem_req.at_we),
    .waddr (mem_req.at_waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.at_re),
    .raddr (mem_req.at_raddr),
    .rdata (at_rdata)
  );

  // color select and output register
  ibar_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_tag   (pix_tag),
    .bm_rdata  (bm_rdata),
    .at_rdata  (at_rdata),
    .pipe_free (pipe_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // no item is taken during the clearing pass
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) status.clearing |-> !in_ready
  ) else $error("item accepted during store clear");

  // a pixel read never shares a cycle with a store write
  a_no_read_write_overlap: assert property (
    @(posedge clk) disable iff (!rst_n)
    (mem_req.bm_re || mem_req.at_re) |-> !(mem_req.bm_we || mem_req.at_we)
  ) else $error("store read and write in the same cycle");

  // no result can exist during the clearing pass
  a_no_result_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) status.clearing |-> !out_valid
  ) else $error("result during store clear");

  // frame end only flags the bottom right pixel
  a_frame_end_position: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.frame_end) |->
      (out_item.pixel_x == 8'd255 && out_item.pixel_y == 8'd191)
  ) else $error("frame end on wrong pixel");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the interleaved bitmap/attribute renderer
// ----------------------------------------------------------------------------
// A clocked driver feeds write and pixel items from a queue of pending items
// that the stimulus process fills. Each accepted item goes through a local
// model of the video store and scan position, which queues the pixel that
// the block must emit. A clocked monitor compares every result against the
// oldest queued pixel, field by field. Stimulus covers the store boundaries,
// writes outside the store, and random traffic aimed at the pixels about to
// be drawn, with one long receiver hold-off and one full drain on the way.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS   = 1280;
  localparam int PENDING_DEPTH  = 64;
  localparam int HOLD_CYCLES    = 400;
  // store clear after reset keeps in_ready low until all 6144 bitmap bytes are zero
  localparam int WATCHDOG_LIMIT = 50000;
  // stretch of random items with no idling on either side
  localparam int QUIET_FROM     = 100;
  localparam int QUIET_TO       = 400;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  ibar_pkg::in_item_t  in_item   = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  ibar_pkg::out_item_t out_item;

  interleaved_bitmap_attribute_render dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // local copy of the renderer state
  logic [7:0] vid_mem [ibar_pkg::STORE_SIZE];
  logic [7:0] scan_line;
  logic [7:0] scan_col;

  ibar_pkg::in_item_t  pending_items [$];
  ibar_pkg::out_item_t pixel_q [$];

  int   fill_pix       = 0;
  int   mismatch_count = 0;
  int   stall_run      = 0;
  int   holdoff_left   = 0;
  logic hold_request   = 1'b0;
  logic quiet          = 1'b0;

  // bitmap line to screen row: swap the two 3-bit groups below bit 6
  function automatic logic [7:0] screen_row(input logic [7:0] line);
    return {line[7:6], line[2:0], line[5:3]};
  endfunction

  // full-intensity color: bit 0 blue, bit 1 red, bit 2 green
  function automatic logic [23:0] rgb_of(input logic [2:0] idx);
    return {{8{idx[1]}}, {8{idx[2]}}, {8{idx[0]}}};
  endfunction

  // update the store or work out the next pixel and step the scan position
  function automatic void render_item(input ibar_pkg::in_item_t it);
    ibar_pkg::out_item_t px;
    logic [7:0] row;
    logic [7:0] bits;
    logic [7:0] attr;
    logic [2:0] cidx;
    int         bm_idx;
    int         at_idx;
    if (it.func == ibar_pkg::FUNC_WRITE) begin
      // writes above the store are dropped
      if (it.addr < ibar_pkg::STORE_SIZE) vid_mem[it.addr] = it.data;
    end else begin
      row    = screen_row(scan_line);
      bm_idx = int'(scan_line) * 32 + int'(scan_col[7:3]);
      at_idx = ibar_pkg::BITMAP_SIZE + int'(row[7:3]) * 32 + int'(scan_col[7:3]);
      bits   = vid_mem[bm_idx];
      attr   = vid_mem[at_idx];
      // msb first within the byte; set bit is ink, clear bit is paper
      cidx   = bits[3'd7 - scan_col[2:0]] ? attr[2:0] : attr[5:3];
      px.pixel_x   = scan_col;
      px.pixel_y   = row;
      px.rgb       = rgb_of(cidx);
      px.frame_end = (scan_line == 8'(ibar_pkg::SCREEN_HEIGHT - 1)) &&
                     (scan_col == 8'(ibar_pkg::SCREEN_WIDTH - 1));
      pixel_q.push_back(px);
      if (scan_col == 8'(ibar_pkg::SCREEN_WIDTH - 1)) begin
        scan_col  = 8'd0;
        scan_line = (scan_line == 8'(ibar_pkg::SCREEN_HEIGHT - 1)) ? 8'd0
                                                                  : scan_line + 8'd1;
      end else begin
        scan_col = scan_col + 8'd1;
      end
    end
  endfunction

  // driver: offers the next pending item, holds it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) render_item(in_item);
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      holdoff_left <= 0;
    end else if (holdoff_left != 0) begin
      out_ready    <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (hold_request) begin
      out_ready    <= 1'b0;
      holdoff_left <= HOLD_CYCLES;
      hold_request <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  // monitor: each result against the oldest predicted pixel
  always @(posedge clk) begin : result_check
    ibar_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("mismatch: unexpected result x=%0d y=%0d rgb=%06h end=%0b",
                   out_item.pixel_x, out_item.pixel_y, out_item.rgb,
                   out_item.frame_end);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = pixel_q.pop_front();
        if (out_item.pixel_x !== want.pixel_x || out_item.pixel_y !== want.pixel_y ||
            out_item.rgb !== want.rgb || out_item.frame_end !== want.frame_end) begin
          if (mismatch_count < 10)
            $display("mismatch: want x=%0d y=%0d rgb=%06h end=%0b, got x=%0d y=%0d rgb=%06h end=%0b",
                     want.pixel_x, want.pixel_y, want.rgb, want.frame_end,
                     out_item.pixel_x, out_item.pixel_y, out_item.rgb,
                     out_item.frame_end);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // watchdog: cycles in a row with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_run <= 0;
    end else if (stall_run >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

  // queue one item, keeping the pending queue bounded
  task automatic queue_item(input ibar_pkg::in_item_t it);
    while (pending_items.size() >= PENDING_DEPTH) @(negedge clk);
    pending_items.push_back(it);
  endtask

  task automatic queue_write(input int addr, input logic [7:0] data);
    ibar_pkg::in_item_t it;
    it.func = ibar_pkg::FUNC_WRITE;
    it.addr = 13'(addr);
    it.data = data;
    queue_item(it);
  endtask

  // addr and data ride along on pixel items and must be ignored
  task automatic queue_pixel(input logic [12:0] addr, input logic [7:0] data);
    ibar_pkg::in_item_t it;
    it.func = ibar_pkg::FUNC_PIXEL;
    it.addr = addr;
    it.data = data;
    queue_item(it);
    fill_pix++;
  endtask

  // write the bitmap or attribute byte a pixel a few steps ahead will read
  task automatic queue_aimed_write(input int ahead);
    int         pos;
    logic [7:0] line;
    logic [7:0] col;
    logic [7:0] row;
    pos  = fill_pix + ahead;
    line = 8'((pos / ibar_pkg::SCREEN_WIDTH) % ibar_pkg::SCREEN_HEIGHT);
    col  = 8'(pos % ibar_pkg::SCREEN_WIDTH);
    row  = screen_row(line);
    if ($urandom_range(1) == 1)
      queue_write(int'(line) * 32 + int'(col[7:3]), 8'($urandom_range(255)));
    else
      queue_write(ibar_pkg::BITMAP_SIZE + int'(row[7:3]) * 32 + int'(col[7:3]),
                  8'($urandom_range(255)));
  endtask

  // sender pause: everything accepted and every pixel back
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || pixel_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int roll;
    for (int i = 0; i < ibar_pkg::STORE_SIZE; i++) vid_mem[i] = 8'h00;
    scan_line = 8'd0;
    scan_col  = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cleared store, ink and paper, store edges, writes past the end
    queue_pixel(13'd0, 8'h00);
    queue_write(0, 8'hA5);
    queue_write(ibar_pkg::BITMAP_SIZE, 8'hC7);
    for (int i = 0; i < 7; i++) queue_pixel(13'h1FFF, 8'hFF);
    queue_write(ibar_pkg::BITMAP_SIZE, 8'h38);
    queue_write(1, 8'h0F);
    queue_pixel(13'h1555, 8'hAA);
    queue_pixel(13'h0AAA, 8'h55);
    queue_write(ibar_pkg::STORE_SIZE, 8'hFF);
    queue_write(8191, 8'hFF);
    queue_write(ibar_pkg::BITMAP_SIZE - 1, 8'hFF);
    queue_write(ibar_pkg::STORE_SIZE - 1, 8'hFF);
    queue_write(ibar_pkg::BITMAP_SIZE + 1, 8'h00);
    queue_pixel(13'd0, 8'h00);
    queue_pixel(13'd0, 8'h00);
    queue_pixel(13'd0, 8'h00);
    wait_drained();

    // random: mostly pixels and writes aimed at the pixels coming next
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= QUIET_FROM) && (n < QUIET_TO);
      if (n == 500) hold_request = 1'b1;
      if (n == 900) wait_drained();
      roll = $urandom_range(99);
      if (roll < 55)
        queue_pixel(13'($urandom_range(8191)), 8'($urandom_range(255)));
      else if (roll < 85)
        queue_aimed_write($urandom_range(15));
      else if (roll < 95)
        queue_write($urandom_range(ibar_pkg::STORE_SIZE - 1), 8'($urandom_range(255)));
      else
        queue_write($urandom_range(8191, ibar_pkg::STORE_SIZE), 8'($urandom_range(255)));
    end
    quiet = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
